FILE: hdl/ats_pkg.sv
package ats_pkg;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_TONE_STEP     = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_VIBRATO_STEP  = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_VIBRATO_DEPTH = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ATTACK_LEN    = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_DECAY_LEN     = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_NOTE_LEN      = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_LEN   = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_GAINS = 4'd7;

    localparam logic [15:0] ENV_ONE     = 16'd32768;
    localparam logic [15:0] ENV_SUSTAIN = 16'd22938;
    localparam logic [15:0] ENV_DROP    = 16'd9830;

    localparam longint unsigned PI_Q30  = 64'd3373259426;
    localparam longint unsigned ONE_Q30 = 64'd1073741824;

    localparam int QUOT_W = 15;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_VPH,
        ST_VIDX,
        ST_VRD,
        ST_TPH,
        ST_TIDX,
        ST_TRD,
        ST_ENV,
        ST_DIV,
        ST_WE,
        ST_GL,
        ST_GR,
        ST_DONE
    } ats_state_t;

    typedef struct packed {
        logic start;
        logic step;
    } ats_div_ctrl_t;

    function automatic logic signed [15:0] sat_tone(input logic signed [47:0] p);
        logic signed [47:0] adj;
        logic signed [17:0] q;
        begin
            adj = p;
            if (p < 0)
            begin
                adj = p + 48'sd1073741823;
            end
            q = 18'(adj >>> 30);
            if (q > 18'sd32767)
            begin
                sat_tone = 16'sd32767;
            end
            else if (q < -18'sd32768)
            begin
                sat_tone = -16'sd32768;
            end
            else
            begin
                sat_tone = 16'(q);
            end
        end
    endfunction

    function automatic logic signed [15:0] mix_sample(input logic signed [15:0] a,
                                                      input logic signed [15:0] b);
        logic signed [16:0] s;
        logic [15:0]        mag;
        logic [31:0]        m;
        logic [16:0]        q;
        begin
            s = 17'(a) + 17'(b);
            if (s > 17'sd32768)
            begin
                s = 17'sd32768;
            end
            mag = s[16] ? 16'(-s) : 16'(s);
            if (s == -17'sd65536)
            begin
                mag = 16'd32768;
            end
            if (s < -17'sd32768)
            begin
                mag = 16'd32768;
            end
            m = ({16'd0, mag} << 15) - {16'd0, mag} + 32'd16384;
            q = 17'(m >> 15);
            mix_sample = s[16] ? 16'(-q) : 16'(q);
        end
    endfunction

endpackage

FILE: hdl/ats_in_if.sv
interface ats_in_if;
    logic               valid;
    logic               ready;
    logic [31:0]        sample_position;
    logic               note_start;
    logic               square_wave;
    logic signed [15:0] prior_left;
    logic signed [15:0] prior_right;

    modport source (output valid, output sample_position, output note_start,
                    output square_wave, output prior_left, output prior_right,
                    input ready);
    modport sink (input valid, input sample_position, input note_start,
                  input square_wave, input prior_left, input prior_right,
                  output ready);
endinterface

FILE: hdl/ats_out_if.sv
interface ats_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] mixed_left;
    logic signed [15:0] mixed_right;

    modport source (output valid, output mixed_left, output mixed_right, input ready);
    modport sink (input valid, input mixed_left, input mixed_right, output ready);
endinterface

FILE: hdl/adsr_tone_synth_mixer_top.sv
// Channel   Direction  Payload
// in_ch     sink       sample_position, note_start, square_wave, prior_left, prior_right
// out_ch    source     mixed_left, mixed_right
// cfg_*     write      cfg_index selects one of eight registers, cfg_data is the value
//
// Each transaction runs through one shared 33x33 multiplier used in nine steps and, when the
// envelope needs a division, through a 15-step restoring divider. The next transaction is
// accepted in the cycle after the result loads.
// Reset clears the registers, the note origin and all control state.
// A new transaction is accepted while a result waits; the next result holds
// in the sequencer until the output register is free.
module adsr_tone_synth_mixer_top
    import ats_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int LENGTH_BITS = 24
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    ats_in_if.sink                 in_ch,
    ats_out_if.source              out_ch
);

    localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH);
    localparam int NUM_W  = LENGTH_BITS + QUOT_W;
    localparam int EW     = 34;

    ats_state_t state_reg, state_next;

    logic [31:0]            tone_step_reg, vib_step_reg;
    logic [15:0]            vib_depth_reg;
    logic [LENGTH_BITS-1:0] attack_reg, decay_reg, note_len_reg, release_reg;
    logic [31:0]            gains_reg;
    logic [31:0]            origin_reg;

    logic [31:0]        pos_reg;
    logic               square_reg;
    logic signed [15:0] prior_l_reg, prior_r_reg;
    logic [31:0]        n_reg;
    logic [31:0]        vph_reg, off_reg;
    logic signed [15:0] wave_reg;
    logic [15:0]        env_reg;
    logic               div_used_reg, div_sub_reg;
    logic [3:0]         div_cnt_reg;
    logic signed [31:0] we_reg;
    logic signed [15:0] tone_l_reg, tone_r_reg;
    logic               out_valid_reg;
    logic signed [15:0] out_l_reg, out_r_reg;

    logic signed [32:0] ma, mb;
    logic signed [65:0] prod;
    logic [ADDR_W-1:0]  rom_addr;
    logic [15:0]        rom_data;
    ats_div_ctrl_t      div_ctrl;
    logic [NUM_W-1:0]   div_num;
    logic [LENGTH_BITS-1:0] div_den;
    logic [QUOT_W-1:0]  quot;
    logic [15:0]        env_use;

    logic [EW-1:0] n_x, a_x, d_x, l_x, r_x;

    assign prod = ma * mb;

    ats_sine_rom #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH), .ADDR_W(ADDR_W)) u_rom
    (
        .clk  (clk),
        .addr (rom_addr),
        .data (rom_data)
    );

    ats_divider #(.LENGTH_BITS(LENGTH_BITS), .NUM_W(NUM_W)) u_div
    (
        .clk  (clk),
        .ctrl (div_ctrl),
        .num  (div_num),
        .den  (div_den),
        .quot (quot)
    );

    assign n_x = EW'(n_reg);
    assign a_x = EW'(attack_reg);
    assign d_x = EW'(decay_reg);
    assign l_x = EW'(note_len_reg);
    assign r_x = EW'(release_reg);

    assign in_ch.ready        = (state_reg == ST_IDLE);
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.mixed_left  = out_l_reg;
    assign out_ch.mixed_right = out_r_reg;

    always_comb
    begin
        if (div_used_reg)
        begin
            env_use = div_sub_reg ? (ENV_ONE - 16'(quot)) : 16'(quot);
        end
        else
        begin
            env_use = env_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ma         = '0;
        mb         = '0;
        rom_addr   = prod[32 +: ADDR_W];
        div_ctrl   = '0;
        div_num    = prod[NUM_W-1:0];
        div_den    = attack_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    state_next = ST_VPH;
                end
            end
            ST_VPH:
            begin
                ma         = {1'b0, vib_step_reg};
                mb         = {1'b0, pos_reg};
                state_next = ST_VIDX;
            end
            ST_VIDX:
            begin
                ma         = {1'b0, vph_reg};
                mb         = 33'(SINE_TABLE_DEPTH);
                state_next = ST_VRD;
            end
            ST_VRD:
            begin
                ma         = {17'd0, vib_depth_reg};
                mb         = {{17{rom_data[15]}}, rom_data};
                state_next = ST_TPH;
            end
            ST_TPH:
            begin
                ma         = {1'b0, tone_step_reg};
                mb         = {1'b0, pos_reg};
                state_next = ST_TIDX;
            end
            ST_TIDX:
            begin
                ma         = {1'b0, vph_reg};
                mb         = 33'(SINE_TABLE_DEPTH);
                state_next = ST_TRD;
            end
            ST_TRD:
            begin
                state_next = ST_ENV;
            end
            ST_ENV:
            begin
                state_next = ST_WE;
                if (n_x >= l_x + r_x)
                begin
                end
                else if (a_x != 0 && n_x < a_x)
                begin
                    ma             = 33'(n_reg[LENGTH_BITS-1:0]);
                    mb             = 33'(ENV_ONE);
                    div_den        = attack_reg;
                    div_ctrl.start = 1'b1;
                    state_next     = ST_DIV;
                end
                else if (d_x != 0 && n_x < a_x + d_x)
                begin
                    ma             = 33'(LENGTH_BITS'(n_x - a_x));
                    mb             = 33'(ENV_DROP);
                    div_den        = decay_reg;
                    div_ctrl.start = 1'b1;
                    state_next     = ST_DIV;
                end
                else if (d_x != 0 && n_x < l_x)
                begin
                end
                else if (r_x != 0 && n_x >= l_x)
                begin
                    ma             = 33'(LENGTH_BITS'(l_x + r_x - n_x));
                    mb             = 33'(ENV_SUSTAIN);
                    div_den        = release_reg;
                    div_ctrl.start = 1'b1;
                    state_next     = ST_DIV;
                end
            end
            ST_DIV:
            begin
                div_ctrl.step = 1'b1;
                if (div_cnt_reg == 4'(QUOT_W - 1))
                begin
                    state_next = ST_WE;
                end
            end
            ST_WE:
            begin
                ma         = {{17{wave_reg[15]}}, wave_reg};
                mb         = {17'd0, env_use};
                state_next = ST_GL;
            end
            ST_GL:
            begin
                ma         = {we_reg[31], we_reg};
                mb         = {17'd0, gains_reg[15:0]};
                state_next = ST_GR;
            end
            ST_GR:
            begin
                ma         = {we_reg[31], we_reg};
                mb         = {17'd0, gains_reg[31:16]};
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            origin_reg    <= '0;
            tone_step_reg <= '0;
            vib_step_reg  <= '0;
            vib_depth_reg <= '0;
            attack_reg    <= '0;
            decay_reg     <= '0;
            note_len_reg  <= '0;
            release_reg   <= '0;
            gains_reg     <= '0;
            div_cnt_reg   <= '0;
            div_used_reg  <= 1'b0;
            div_sub_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TONE_STEP:     tone_step_reg <= cfg_data;
                    REG_VIBRATO_STEP:  vib_step_reg  <= cfg_data;
                    REG_VIBRATO_DEPTH: vib_depth_reg <= cfg_data[15:0];
                    REG_ATTACK_LEN:    attack_reg    <= cfg_data[LENGTH_BITS-1:0];
                    REG_DECAY_LEN:     decay_reg     <= cfg_data[LENGTH_BITS-1:0];
                    REG_NOTE_LEN:      note_len_reg  <= cfg_data[LENGTH_BITS-1:0];
                    REG_RELEASE_LEN:   release_reg   <= cfg_data[LENGTH_BITS-1:0];
                    REG_CHANNEL_GAINS: gains_reg     <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (state_reg == ST_IDLE && in_ch.valid && in_ch.note_start)
            begin
                origin_reg <= in_ch.sample_position;
            end
            if (state_reg == ST_ENV)
            begin
                div_used_reg <= (state_next == ST_DIV);
                div_sub_reg  <= !(a_x != 0 && n_x < a_x) && (d_x != 0 && n_x < a_x + d_x);
                div_cnt_reg  <= '0;
            end
            else if (state_reg == ST_DIV)
            begin
                div_cnt_reg <= div_cnt_reg + 4'd1;
            end
            if (state_reg == ST_DONE && state_next == ST_IDLE)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                pos_reg     <= in_ch.sample_position;
                square_reg  <= in_ch.square_wave;
                prior_l_reg <= in_ch.prior_left;
                prior_r_reg <= in_ch.prior_right;
                n_reg       <= in_ch.sample_position -
                               (in_ch.note_start ? in_ch.sample_position : origin_reg);
            end
            ST_VPH:
            begin
                vph_reg <= prod[31:0];
            end
            ST_VRD:
            begin
                off_reg <= {prod[30:0], 1'b0};
            end
            ST_TPH:
            begin
                vph_reg <= prod[31:0] + off_reg;
            end
            ST_TRD:
            begin
                if (square_reg)
                begin
                    wave_reg <= ($signed(rom_data) > 16'sd0) ? 16'sd32767 : -16'sd32767;
                end
                else
                begin
                    wave_reg <= $signed(rom_data);
                end
            end
            ST_ENV:
            begin
                if (n_x >= l_x + r_x)
                begin
                    env_reg <= '0;
                end
                else if (d_x != 0 && n_x >= a_x + d_x && n_x < l_x)
                begin
                    env_reg <= ENV_SUSTAIN;
                end
                else
                begin
                    env_reg <= ENV_ONE;
                end
            end
            ST_WE:
            begin
                we_reg <= prod[31:0];
            end
            ST_GL:
            begin
                tone_l_reg <= sat_tone(prod[47:0]);
            end
            ST_GR:
            begin
                tone_r_reg <= sat_tone(prod[47:0]);
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_l_reg <= mix_sample(tone_l_reg, prior_l_reg);
                    out_r_reg <= mix_sample(tone_r_reg, prior_r_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

FILE: hdl/ats_sine_rom.sv
module ats_sine_rom
    import ats_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int ADDR_W = $clog2(SINE_TABLE_DEPTH)
)
(
    input  logic              clk,
    input  logic [ADDR_W-1:0] addr,
    output logic [15:0]       data
);

    function automatic logic [15:0] sine_entry(input int unsigned k);
        longint unsigned r;
        longint unsigned quad;
        longint unsigned rem;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned v;
        longint          sum;
        begin
            r    = longint'(k) * 4;
            quad = r / SINE_TABLE_DEPTH;
            rem  = r % SINE_TABLE_DEPTH;
            if (quad[0])
            begin
                rem = SINE_TABLE_DEPTH - rem;
            end
            x    = (PI_Q30 * rem) / (2 * SINE_TABLE_DEPTH);
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            // The series terms have all reached zero well before the tenth one.
            term = ((term * x2) >> 30) / 6;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 20;
            sum  = sum + longint'(term);
            term = ((term * x2) >> 30) / 42;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 72;
            sum  = sum + longint'(term);
            term = ((term * x2) >> 30) / 110;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 156;
            sum  = sum + longint'(term);
            term = ((term * x2) >> 30) / 210;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 272;
            sum  = sum + longint'(term);
            term = ((term * x2) >> 30) / 342;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 420;
            sum  = sum + longint'(term);
            if (sum < 0)
            begin
                sum = 0;
            end
            v = (longint'(sum) * 32767 + ONE_Q30 / 2) >> 30;
            if (v > 32767)
            begin
                v = 32767;
            end
            sine_entry = (quad >= 2) ? 16'(-v) : 16'(v);
        end
    endfunction

    logic [15:0] rom [SINE_TABLE_DEPTH];

    for (genvar k = 0; k < SINE_TABLE_DEPTH; k++)
    begin : g_rom
        localparam logic [15:0] ENTRY = sine_entry(k);
        assign rom[k] = ENTRY;
    end

    always_ff @(posedge clk)
    begin
        data <= rom[addr];
    end

endmodule

FILE: hdl/ats_divider.sv
module ats_divider
    import ats_pkg::*;
#(
    parameter int LENGTH_BITS = 24,
    parameter int NUM_W = LENGTH_BITS + QUOT_W
)
(
    input  logic                   clk,
    input  ats_div_ctrl_t          ctrl,
    input  logic [NUM_W-1:0]       num,
    input  logic [LENGTH_BITS-1:0] den,
    output logic [QUOT_W-1:0]      quot
);

    logic [NUM_W-1:0]  rem_reg, rem_next;
    logic [NUM_W-1:0]  dsh_reg, dsh_next;
    logic [QUOT_W-1:0] q_reg, q_next;

    always_comb
    begin
        rem_next = rem_reg;
        dsh_next = dsh_reg;
        q_next   = q_reg;
        if (ctrl.start)
        begin
            rem_next = num;
            dsh_next = NUM_W'({den, {(QUOT_W-1){1'b0}}});
            q_next   = '0;
        end
        else if (ctrl.step)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_next = rem_reg - dsh_reg;
                q_next   = {q_reg[QUOT_W-2:0], 1'b1};
            end
            else
            begin
                q_next = {q_reg[QUOT_W-2:0], 1'b0};
            end
            dsh_next = dsh_reg >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
    end

    assign quot = q_reg;

endmodule

FILE: tb/sv/tb_adsr_tone_synth_mixer_top.sv
`timescale 1ns / 1ps

module tb_adsr_tone_synth_mixer_top
    import ats_pkg::*;
();

    localparam int TABLE_DEPTH = 1024;
    localparam int LEN_BITS = 24;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 5000;
    localparam int NUM_PHASES = 12;
    localparam int ITEMS_PER_PHASE = 162;

    typedef struct {
        bit [31:0]   pos;
        bit          start;
        bit          square;
        shortint     left;
        shortint     right;
        bit          typed;
        shortint     exp_left;
        shortint     exp_right;
    } slot_t;

    typedef struct {
        shortint left;
        shortint right;
    } stereo_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ats_in_if in_ch ();
    ats_out_if out_ch ();

    adsr_tone_synth_mixer_top #(
        .SINE_TABLE_DEPTH(TABLE_DEPTH),
        .LENGTH_BITS(LEN_BITS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_ch(in_ch),
        .out_ch(out_ch)
    );

    shortint sine_lut[TABLE_DEPTH];
    bit [31:0] tone_step_r, vib_step_r, vib_depth_r;
    bit [31:0] attack_r, decay_r, note_r, release_r, gains_r;
    bit [31:0] origin_r;

    stereo_t mix_q[$];
    slot_t directed_rows[$];
    int mismatches;
    int stall_count;
    bit no_idle;
    bit hold_req;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic shortint quarter_wave(longint unsigned x);
        longint unsigned x2;
        longint unsigned term;
        longint unsigned k;
        longint unsigned v;
        longint sum;
        bit neg;
        x2 = (x * x) >> 30;
        term = x;
        sum = x;
        k = 1;
        neg = 1'b1;
        while (term != 0)
        begin
            term = ((term * x2) >> 30) / ((k + 1) * (k + 2));
            k += 2;
            if (neg)
            begin
                sum -= term;
            end
            else
            begin
                sum += term;
            end
            neg = !neg;
        end
        if (sum < 0)
        begin
            sum = 0;
        end
        v = (longint'(sum) * 64'd32767 + ONE_Q30 / 2) >> 30;
        if (v > 32767)
        begin
            v = 32767;
        end
        return shortint'(v);
    endfunction

    function automatic void fill_sine_lut();
        longint unsigned r;
        longint unsigned quad;
        longint unsigned rem;
        shortint s;
        for (int k = 0; k < TABLE_DEPTH; k++)
        begin
            r = k * 4;
            quad = r / TABLE_DEPTH;
            rem = r % TABLE_DEPTH;
            if (quad[0])
            begin
                rem = TABLE_DEPTH - rem;
            end
            s = quarter_wave((PI_Q30 * rem) / (2 * TABLE_DEPTH));
            sine_lut[k] = (quad >= 2) ? -s : s;
        end
    endfunction

    function automatic longint lut_sine(bit [31:0] phase);
        longint unsigned idx;
        idx = phase;
        idx = (idx * TABLE_DEPTH) >> 32;
        return sine_lut[idx % TABLE_DEPTH];
    endfunction

    function automatic longint unsigned envelope_level(longint unsigned n);
        longint unsigned a;
        longint unsigned d;
        longint unsigned l;
        longint unsigned r;
        a = attack_r;
        d = decay_r;
        l = note_r;
        r = release_r;
        if (n >= l + r)
        begin
            return 0;
        end
        if (a > 0 && n < a)
        begin
            return (n << 15) / a;
        end
        if (d > 0 && n < a + d)
        begin
            return ENV_ONE - ((n - a) * ENV_DROP) / d;
        end
        if (d > 0 && n < l)
        begin
            return ENV_SUSTAIN;
        end
        if (r > 0 && n >= l)
        begin
            if (n - l < r)
            begin
                return (ENV_SUSTAIN * (r - (n - l))) / r;
            end
            return 0;
        end
        return ENV_ONE;
    endfunction

    function automatic shortint mix_into(longint a, longint b);
        longint s;
        longint t;
        longint m;
        longint q;
        s = a + b;
        if (s > 32768)
        begin
            s = 32768;
        end
        if (s < -32768)
        begin
            s = -32768;
        end
        t = s * 32767;
        m = (t < 0) ? -t : t;
        q = (m + 16384) >>> 15;
        return shortint'((t < 0) ? -q : q);
    endfunction

    function automatic stereo_t synth_and_mix(slot_t it);
        stereo_t res;
        bit [31:0] n;
        bit [31:0] phase;
        longint off;
        longint wave;
        longint env;
        longint gain;
        longint tone;
        shortint mixed[2];
        if (it.start)
        begin
            origin_r = it.pos;
        end
        n = it.pos - origin_r;
        off = longint'(vib_depth_r) * lut_sine(vib_step_r * it.pos) * 2;
        phase = tone_step_r * it.pos + off[31:0];
        wave = lut_sine(phase);
        if (it.square)
        begin
            wave = (wave > 0) ? 32767 : -32767;
        end
        env = envelope_level(n);
        for (int j = 0; j < 2; j++)
        begin
            gain = (gains_r >> (16 * j)) & 32'hFFFF;
            tone = (wave * env * gain) / (64'sd1 << 30);
            if (tone > 32767)
            begin
                tone = 32767;
            end
            if (tone < -32768)
            begin
                tone = -32768;
            end
            mixed[j] = mix_into(tone, (j == 0) ? it.left : it.right);
        end
        res.left = mixed[0];
        res.right = mixed[1];
        return res;
    endfunction

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, bit [31:0] value);
        bit [31:0] len_mask;
        len_mask = (32'd1 << LEN_BITS) - 1;
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        case (idx)
            REG_TONE_STEP: tone_step_r = value;
            REG_VIBRATO_STEP: vib_step_r = value;
            REG_VIBRATO_DEPTH: vib_depth_r = value & 32'hFFFF;
            REG_ATTACK_LEN: attack_r = value & len_mask;
            REG_DECAY_LEN: decay_r = value & len_mask;
            REG_NOTE_LEN: note_r = value & len_mask;
            REG_RELEASE_LEN: release_r = value & len_mask;
            REG_CHANNEL_GAINS: gains_r = value;
            default: ;
        endcase
    endtask

    task automatic write_all(bit [31:0] v0, bit [31:0] v1, bit [31:0] v2, bit [31:0] v3,
                             bit [31:0] v4, bit [31:0] v5, bit [31:0] v6, bit [31:0] v7);
        write_reg(REG_TONE_STEP, v0);
        write_reg(REG_VIBRATO_STEP, v1);
        write_reg(REG_VIBRATO_DEPTH, v2);
        write_reg(REG_ATTACK_LEN, v3);
        write_reg(REG_DECAY_LEN, v4);
        write_reg(REG_NOTE_LEN, v5);
        write_reg(REG_RELEASE_LEN, v6);
        write_reg(REG_CHANNEL_GAINS, v7);
        write_reg(REG_CHANNEL_GAINS + 4'($urandom_range(1, 8)), $urandom);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (mix_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_slot(slot_t it);
        stereo_t want;
        if (!no_idle && $urandom_range(0, 7) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.sample_position <= it.pos;
        in_ch.note_start <= it.start;
        in_ch.square_wave <= it.square;
        in_ch.prior_left <= it.left;
        in_ch.prior_right <= it.right;
        do
        begin
            @(posedge clk);
        end
        while (!in_ch.ready);
        want = synth_and_mix(it);
        if (it.typed)
        begin
            want.left = it.exp_left;
            want.right = it.exp_right;
        end
        mix_q.push_back(want);
    endtask

    task automatic add_row(bit [31:0] pos, bit start, bit square, shortint l, shortint r,
                           bit typed, shortint el, shortint er);
        slot_t it;
        it.pos = pos;
        it.start = start;
        it.square = square;
        it.left = l;
        it.right = r;
        it.typed = typed;
        it.exp_left = el;
        it.exp_right = er;
        directed_rows.push_back(it);
    endtask

    function automatic slot_t random_slot(bit [31:0] pos, bit start);
        slot_t it;
        it.pos = pos;
        it.start = start;
        it.square = $urandom_range(0, 1);
        it.left = shortint'($urandom);
        it.right = shortint'($urandom);
        it.typed = 1'b0;
        if ($urandom_range(0, 9) == 0)
        begin
            it.left = ($urandom_range(0, 1) != 0) ? 16'sh7FFF : -16'sh8000;
            it.right = ($urandom_range(0, 1) != 0) ? 16'sh7FFF : -16'sh8000;
        end
        return it;
    endfunction

    task automatic random_config(int mode);
        bit [31:0] v[8];
        for (int i = 0; i < 8; i++)
        begin
            v[i] = $urandom;
        end
        case (mode)
            0:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    v[i] = 32'hFFFF_FFFF;
                end
            end
            1:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    v[i] = 32'd0;
                end
            end
            2:
            begin
                for (int i = 3; i < 7; i++)
                begin
                    v[i] = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 40);
                end
                v[7][15] = $urandom_range(0, 3) == 0;
                v[7][31] = $urandom_range(0, 3) == 0;
            end
            default: ;
        endcase
        write_all(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]);
    endtask

    always @(posedge clk)
    begin
        stereo_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (mix_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("Unexpected transaction: left %0d right %0d",
                             out_ch.mixed_left, out_ch.mixed_right);
                end
            end
            else
            begin
                want = mix_q.pop_front();
                if (out_ch.mixed_left !== want.left || out_ch.mixed_right !== want.right)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("Mismatch: expected left %0d right %0d, got left %0d right %0d",
                                 want.left, want.right, out_ch.mixed_left, out_ch.mixed_right);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        begin
            stall_count <= 0;
        end
        else
        begin
            stall_count <= stall_count + 1;
            if (stall_count >= STALL_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!no_idle && $urandom_range(0, 7) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
        end
    end

    initial
    begin
        bit [31:0] pos;
        int sent;
        int note_len;
        slot_t it;
        bit hold_done;
        bit pause_done;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.sample_position = '0;
        in_ch.note_start = 1'b0;
        in_ch.square_wave = 1'b0;
        in_ch.prior_left = '0;
        in_ch.prior_right = '0;
        mismatches = 0;
        stall_count = 0;
        no_idle = 1'b0;
        hold_req = 1'b0;
        hold_done = 1'b0;
        pause_done = 1'b0;
        origin_r = 0;
        tone_step_r = 0;
        vib_step_r = 0;
        vib_depth_r = 0;
        attack_r = 0;
        decay_r = 0;
        note_r = 0;
        release_r = 0;
        gains_r = 0;
        fill_sine_lut();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // With all gains at zero after reset, only the mix of the prior pair remains.
        add_row(32'd0, 1'b0, 1'b0, 16'sd0, 16'sd0, 1'b1, 16'sd0, 16'sd0);
        add_row(32'hFFFF_FFFF, 1'b1, 1'b1, 16'sh7FFF, -16'sh8000, 1'b1, 16'sd32766, -16'sd32767);
        add_row(32'h8000_0000, 1'b0, 1'b0, -16'sh8000, -16'sh8000, 1'b1,
                -16'sd32767, -16'sd32767);
        add_row(32'h7FFF_FFFF, 1'b0, 1'b1, 16'sh7FFF, 16'sh7FFF, 1'b1, 16'sd32766, 16'sd32766);
        add_row(32'h5555_AAAA, 1'b1, 1'b0, 16'sd1, -16'sd1, 1'b1, 16'sd1, -16'sd1);
        for (int i = 0; i < 5; i++)
        begin
            send_slot(directed_rows[i]);
        end
        in_ch.valid <= 1'b0;
        drain();

        // Short note walking attack, decay, sustain, release and past the note span.
        write_all(32'h0147_AE14, 32'h0010_0000, 32'd65535, 32'd4, 32'd3, 32'd10, 32'd5,
                  32'hFFFF_8000);
        for (int k = 0; k < 17; k++)
        begin
            add_row(32'd100 + k, k == 0, k[0], (k % 3 == 0) ? 16'sh7FFF : 16'sd0,
                    (k % 4 == 1) ? -16'sh8000 : 16'sd300, 1'b0, 16'sd0, 16'sd0);
        end
        for (int i = 5; i < directed_rows.size(); i++)
        begin
            send_slot(directed_rows[i]);
        end
        in_ch.valid <= 1'b0;
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            random_config((ph < 4) ? ph : ((ph % 3 == 0) ? 3 : 2));
            no_idle = (ph == NUM_PHASES - 1);
            sent = 0;
            pos = $urandom;
            while (sent < ITEMS_PER_PHASE)
            begin
                if (ph == 3 && sent >= 40 && !hold_done)
                begin
                    hold_done = 1'b1;
                    hold_req = 1'b1;
                end
                if (ph == 6 && sent >= 80 && !pause_done)
                begin
                    pause_done = 1'b1;
                    in_ch.valid <= 1'b0;
                    while (mix_q.size() != 0)
                    begin
                        @(posedge clk);
                    end
                end
                if ($urandom_range(0, 9) == 0)
                begin
                    send_slot(random_slot($urandom, $urandom_range(0, 1)));
                    sent++;
                end
                else
                begin
                    if ($urandom_range(0, 2) == 0)
                    begin
                        pos = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFC0 : $urandom;
                    end
                    note_len = $urandom_range(1, 120);
                    for (int k = 0; k < note_len && sent < ITEMS_PER_PHASE; k++)
                    begin
                        it = random_slot(pos, k == 0);
                        send_slot(it);
                        sent++;
                        pos += ($urandom_range(0, 15) == 0) ? $urandom_range(2, 5) : 1;
                    end
                end
            end
            in_ch.valid <= 1'b0;
            drain();
        end

        if (mismatches == 0 && mix_q.size() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: adsr_tone_synth_mixer_top.f
hdl/ats_pkg.sv
hdl/ats_in_if.sv
hdl/ats_out_if.sv
hdl/ats_sine_rom.sv
hdl/ats_divider.sv
hdl/adsr_tone_synth_mixer_top.sv
tb/sv/tb_adsr_tone_synth_mixer_top.sv
